[design/spca_pkg.sv]
package spca_pkg;

    // Fixed field widths
    localparam int COORD_W     = 32;
    localparam int DIR_W       = 16;
    localparam int LIGHT_DIR_W = 3 * DIR_W;
    localparam int COS_W       = 15;
    localparam int RANGE_W     = 31;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = LIGHT_DIR_W;

    // Internal datapath widths
    localparam int DIFF_W   = COORD_W + 1;
    localparam int MAG_W    = RANGE_W;
    localparam int SQ_W     = 2 * MAG_W;
    localparam int SUMSQ_W  = 64;
    localparam int PROD_W   = DIR_W + DIFF_W;
    localparam int DOT_W    = PROD_W + 1;
    localparam int DMAG_W   = DOT_W - 1;
    localparam int LEN_W    = MAG_W;
    localparam int QUO_W    = 17;
    localparam int C_W      = QUO_W + 1;
    localparam int GAP_W    = COS_W + 1;
    localparam int FACTOR_W = 16;

    localparam int COORD_FRAC_BITS    = 16;
    localparam int UNIT_FRAC_BITS_DEF = 14;

    localparam logic [31:0] COS30_Q30 = 32'd929887697;
    localparam logic [31:0] COS45_Q30 = 32'd759250125;
    localparam logic [RANGE_W-1:0] RANGE_RESET = RANGE_W'(64'd10 << COORD_FRAC_BITS);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_POS_X       = 3'd0,
        CFG_POS_Y       = 3'd1,
        CFG_POS_Z       = 3'd2,
        CFG_LIGHT_DIR   = 3'd3,
        CFG_COS_INNER   = 3'd4,
        CFG_COS_OUTER   = 3'd5,
        CFG_LIGHT_RANGE = 3'd6
    } cfg_idx_t;

    typedef struct packed {
        logic [DMAG_W-1:0] dmag;
        logic              dneg;
        logic              out;
        logic              zero;
    } side_t;

    function automatic logic [COS_W-1:0] cos_q30_to_unit(input int unsigned u,
                                                         input logic [31:0] q30);
        logic [32:0] s;
        s = 33'(q30) + (33'(1) << (29 - u));
        return COS_W'(s >> (30 - u));
    endfunction

    function automatic logic [LIGHT_DIR_W-1:0] dir_reset(input int unsigned u);
        logic [DIR_W-1:0] y;
        y = DIR_W'(17'h10000 - (17'(1) << u));
        return {{DIR_W{1'b0}}, y, {DIR_W{1'b0}}};
    endfunction

endpackage

[design/spotlight_cone_attenuation_unit.sv]
// Channel  Direction  Signals                                         Transaction
// s_       in         s_valid s_ready s_point_x s_point_y s_point_z   one point
// m_       out        m_valid m_ready m_is_lit m_spot_factor          one result
// cfg_     in         cfg_valid cfg_ready cfg_index cfg_data          one register write
//
// One point is taken per cycle unless the output stalls; each result passes through
// the 31-step square root, the 17-step cosine divider and the UNIT_FRAC_BITS+1 step
// blend divider. Reset is synchronous and active low; it empties the pipeline and
// loads the register defaults. A stall on m_ready freezes every stage; a one-entry
// input buffer keeps s_ready high for one more transaction during a stall.
module spotlight_cone_attenuation_unit
    import spca_pkg::*;
#(
    parameter int UNIT_FRAC_BITS = UNIT_FRAC_BITS_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic signed [COORD_W-1:0]    s_point_x,
    input  logic signed [COORD_W-1:0]    s_point_y,
    input  logic signed [COORD_W-1:0]    s_point_z,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic                         m_is_lit,
    output logic [COS_W-1:0]             m_spot_factor,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [CFG_IDX_W-1:0]         cfg_index,
    input  logic [CFG_DATA_W-1:0]        cfg_data
);

    localparam int SQRT_STEPS  = LEN_W;
    localparam int BLEND_STEPS = UNIT_FRAC_BITS + 1;
    localparam logic [FACTOR_W-1:0] UNIT_ONE = FACTOR_W'(1) << UNIT_FRAC_BITS;

    // Configuration registers
    logic signed [COORD_W-1:0] pos_reg [3];
    logic [LIGHT_DIR_W-1:0]    light_dir_reg;
    logic [COS_W-1:0]          cos_inner_reg;
    logic [COS_W-1:0]          cos_outer_reg;
    logic [RANGE_W-1:0]        light_range_reg;
    logic [SQ_W-1:0]           range_sq_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg[0]      <= '0;
            pos_reg[1]      <= '0;
            pos_reg[2]      <= '0;
            light_dir_reg   <= dir_reset(UNIT_FRAC_BITS);
            cos_inner_reg   <= cos_q30_to_unit(UNIT_FRAC_BITS, COS30_Q30);
            cos_outer_reg   <= cos_q30_to_unit(UNIT_FRAC_BITS, COS45_Q30);
            light_range_reg <= RANGE_RESET;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_POS_X:       pos_reg[0]      <= cfg_data[COORD_W-1:0];
                CFG_POS_Y:       pos_reg[1]      <= cfg_data[COORD_W-1:0];
                CFG_POS_Z:       pos_reg[2]      <= cfg_data[COORD_W-1:0];
                CFG_LIGHT_DIR:   light_dir_reg   <= cfg_data;
                CFG_COS_INNER:   cos_inner_reg   <= cfg_data[COS_W-1:0];
                CFG_COS_OUTER:   cos_outer_reg   <= cfg_data[COS_W-1:0];
                CFG_LIGHT_RANGE: light_range_reg <= cfg_data[RANGE_W-1:0];
                default: ;
            endcase
        end
    end

    // The squared range follows the register in the next cycle; the user changes
    // configuration only while the pipeline is empty (not enforced by the block).
    always_ff @(posedge aclk) begin
        range_sq_reg <= light_range_reg * light_range_reg;
    end

    logic signed [DIR_W-1:0] dir [3];
    for (genvar i = 0; i < 3; i++) begin : g_dir
        assign dir[i] = light_dir_reg[DIR_W*i +: DIR_W];
    end

    // Pipeline advance and input buffer
    logic adv;
    logic m_valid_reg;
    logic skid_valid_reg;
    logic signed [COORD_W-1:0] skid_pt_reg [3];
    logic src_valid;
    logic signed [COORD_W-1:0] src_pt [3];

    assign adv     = !m_valid_reg || m_ready;
    assign s_ready = !skid_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            skid_valid_reg <= 1'b0;
        end else if (adv) begin
            skid_valid_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!adv && s_valid && s_ready) begin
            skid_pt_reg[0] <= s_point_x;
            skid_pt_reg[1] <= s_point_y;
            skid_pt_reg[2] <= s_point_z;
        end
    end

    always_comb begin
        src_valid = skid_valid_reg || s_valid;
        if (skid_valid_reg) begin
            src_pt = skid_pt_reg;
        end else begin
            src_pt[0] = s_point_x;
            src_pt[1] = s_point_y;
            src_pt[2] = s_point_z;
        end
    end

    // Stage A: offset from the light
    logic                     a_valid_reg;
    logic signed [DIFF_W-1:0] a_d_reg [3];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else if (adv) begin
            a_valid_reg <= src_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int i = 0; i < 3; i++) begin
                a_d_reg[i] <= DIFF_W'(src_pt[i]) - DIFF_W'(pos_reg[i]);
            end
        end
    end

    // Stage B: per-axis range check, squares and direction products
    logic [DIFF_W-1:0] a_mag [3];
    logic              a_oor;

    always_comb begin
        a_oor = 1'b0;
        for (int i = 0; i < 3; i++) begin
            a_mag[i] = a_d_reg[i][DIFF_W-1] ? DIFF_W'(-a_d_reg[i]) : DIFF_W'(a_d_reg[i]);
            if (a_mag[i] > DIFF_W'(light_range_reg)) begin
                a_oor = 1'b1;
            end
        end
    end

    logic                     b_valid_reg;
    logic                     b_oor_reg;
    logic [SQ_W-1:0]          b_sq_reg [3];
    logic signed [PROD_W-1:0] b_prod_reg [3];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg <= 1'b0;
        end else if (adv) begin
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            b_oor_reg <= a_oor;
            for (int i = 0; i < 3; i++) begin
                b_sq_reg[i]   <= a_mag[i][MAG_W-1:0] * a_mag[i][MAG_W-1:0];
                b_prod_reg[i] <= PROD_W'(dir[i]) * PROD_W'(a_d_reg[i]);
            end
        end
    end

    // Stage C: sums
    logic                    c_valid_reg;
    logic                    c_oor_reg;
    logic [SUMSQ_W-1:0]      c_sumsq_reg;
    logic signed [DOT_W-1:0] c_dot_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c_valid_reg <= 1'b0;
        end else if (adv) begin
            c_valid_reg <= b_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            c_oor_reg   <= b_oor_reg;
            c_sumsq_reg <= SUMSQ_W'(b_sq_reg[0]) + SUMSQ_W'(b_sq_reg[1])
                         + SUMSQ_W'(b_sq_reg[2]);
            c_dot_reg   <= DOT_W'(b_prod_reg[0]) + DOT_W'(b_prod_reg[1])
                         + DOT_W'(b_prod_reg[2]);
        end
    end

    // Stage D: range decision, then the square root pipeline
    logic [DOT_W-1:0] c_dot_mag;
    side_t            c_side;

    always_comb begin
        c_dot_mag   = c_dot_reg[DOT_W-1] ? DOT_W'(-c_dot_reg) : DOT_W'(c_dot_reg);
        c_side.dmag = c_dot_mag[DMAG_W-1:0];
        c_side.dneg = c_dot_reg[DOT_W-1];
        c_side.out  = c_oor_reg || (c_sumsq_reg > SUMSQ_W'(range_sq_reg));
        c_side.zero = (c_sumsq_reg == '0);
    end

    logic            sq_valid_reg [SQRT_STEPS+1];
    logic [SQ_W-1:0] sq_x_reg     [SQRT_STEPS+1];
    logic [SQ_W-1:0] sq_r_reg     [SQRT_STEPS+1];
    side_t           sq_side_reg  [SQRT_STEPS+1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sq_valid_reg[0] <= 1'b0;
        end else if (adv) begin
            sq_valid_reg[0] <= c_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            sq_x_reg[0]    <= c_sumsq_reg[SQ_W-1:0];
            sq_r_reg[0]    <= '0;
            sq_side_reg[0] <= c_side;
        end
    end

    for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
        localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << (SQ_W - 2 - 2 * k);
        logic [SQ_W:0]   trial;
        logic [SQ_W-1:0] x_next;
        logic [SQ_W-1:0] r_next;

        always_comb begin
            trial = (SQ_W+1)'(sq_r_reg[k]) + (SQ_W+1)'(BIT);
            if ((SQ_W+1)'(sq_x_reg[k]) >= trial) begin
                x_next = sq_x_reg[k] - trial[SQ_W-1:0];
                r_next = (sq_r_reg[k] >> 1) + BIT;
            end else begin
                x_next = sq_x_reg[k];
                r_next = sq_r_reg[k] >> 1;
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                sq_valid_reg[k+1] <= 1'b0;
            end else if (adv) begin
                sq_valid_reg[k+1] <= sq_valid_reg[k];
            end
        end

        always_ff @(posedge aclk) begin
            if (adv) begin
                sq_x_reg[k+1]    <= x_next;
                sq_r_reg[k+1]    <= r_next;
                sq_side_reg[k+1] <= sq_side_reg[k];
            end
        end
    end

    // Cosine divider: |dot| / length, one quotient bit per stage
    logic              dv_valid_reg [QUO_W+1];
    logic [DMAG_W-1:0] dv_rem_reg   [QUO_W+1];
    logic [LEN_W-1:0]  dv_len_reg   [QUO_W+1];
    logic [QUO_W-1:0]  dv_q_reg     [QUO_W+1];
    side_t             dv_side_reg  [QUO_W+1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dv_valid_reg[0] <= 1'b0;
        end else if (adv) begin
            dv_valid_reg[0] <= sq_valid_reg[SQRT_STEPS];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            dv_rem_reg[0]  <= sq_side_reg[SQRT_STEPS].dmag;
            dv_len_reg[0]  <= sq_r_reg[SQRT_STEPS][LEN_W-1:0];
            dv_q_reg[0]    <= '0;
            dv_side_reg[0] <= sq_side_reg[SQRT_STEPS];
        end
    end

    for (genvar k = 0; k < QUO_W; k++) begin : g_div
        localparam int SH = QUO_W - 1 - k;
        logic [DMAG_W-1:0] sub;
        logic              take;

        always_comb begin
            sub  = DMAG_W'(dv_len_reg[k]) << SH;
            take = (dv_rem_reg[k] >= sub);
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                dv_valid_reg[k+1] <= 1'b0;
            end else if (adv) begin
                dv_valid_reg[k+1] <= dv_valid_reg[k];
            end
        end

        always_ff @(posedge aclk) begin
            if (adv) begin
                dv_rem_reg[k+1]  <= take ? dv_rem_reg[k] - sub : dv_rem_reg[k];
                dv_len_reg[k+1]  <= dv_len_reg[k];
                dv_q_reg[k+1]    <= dv_q_reg[k] | (take ? (QUO_W'(1) << SH) : '0);
                dv_side_reg[k+1] <= dv_side_reg[k];
            end
        end
    end

    // Stage E: cone tests, then the blend divider
    logic signed [C_W-1:0]   cosv;
    logic signed [C_W-1:0]   co_s;
    logic signed [C_W-1:0]   ci_s;
    logic signed [GAP_W-1:0] gap;
    logic signed [C_W-1:0]   num_s;
    logic                    e_lit;
    logic                    e_full;
    side_t                   dv_last;

    always_comb begin
        dv_last = dv_side_reg[QUO_W];
        cosv    = dv_last.dneg ? -$signed(C_W'(dv_q_reg[QUO_W]))
                               : $signed(C_W'(dv_q_reg[QUO_W]));
        co_s    = $signed(C_W'(cos_outer_reg));
        ci_s    = $signed(C_W'(cos_inner_reg));
        gap     = $signed(GAP_W'(cos_inner_reg)) - $signed(GAP_W'(cos_outer_reg));
        num_s   = cosv - co_s;
        e_lit   = 1'b0;
        e_full  = 1'b0;
        if (dv_last.out) begin
            e_lit = 1'b0;
        end else if (dv_last.zero) begin
            e_lit  = 1'b1;
            e_full = 1'b1;
        end else if (cosv < co_s) begin
            e_lit = 1'b0;
        end else begin
            e_lit  = 1'b1;
            e_full = (cosv > ci_s) || (gap < GAP_W'(1));
        end
    end

    logic                bl_valid_reg [BLEND_STEPS+1];
    logic [GAP_W-1:0]    bl_rem_reg   [BLEND_STEPS+1];
    logic [COS_W-1:0]    bl_gap_reg   [BLEND_STEPS+1];
    logic [FACTOR_W-1:0] bl_q_reg     [BLEND_STEPS+1];
    logic                bl_lit_reg   [BLEND_STEPS+1];
    logic                bl_full_reg  [BLEND_STEPS+1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bl_valid_reg[0] <= 1'b0;
        end else if (adv) begin
            bl_valid_reg[0] <= dv_valid_reg[QUO_W];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            bl_rem_reg[0]  <= GAP_W'(num_s[COS_W-1:0]);
            bl_gap_reg[0]  <= gap[COS_W-1:0];
            bl_q_reg[0]    <= '0;
            bl_lit_reg[0]  <= e_lit;
            bl_full_reg[0] <= e_full;
        end
    end

    // The numerator never exceeds the gap, so the first step yields the
    // integer bit and each later step doubles the remainder.
    for (genvar k = 0; k < BLEND_STEPS; k++) begin : g_blend
        localparam int W = UNIT_FRAC_BITS - k;
        logic [GAP_W-1:0] trial;
        logic             take;

        always_comb begin
            trial = (k == 0) ? bl_rem_reg[k] : (bl_rem_reg[k] << 1);
            take  = (trial >= GAP_W'(bl_gap_reg[k]));
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                bl_valid_reg[k+1] <= 1'b0;
            end else if (adv) begin
                bl_valid_reg[k+1] <= bl_valid_reg[k];
            end
        end

        always_ff @(posedge aclk) begin
            if (adv) begin
                bl_rem_reg[k+1]  <= take ? trial - GAP_W'(bl_gap_reg[k]) : trial;
                bl_gap_reg[k+1]  <= bl_gap_reg[k];
                bl_q_reg[k+1]    <= bl_q_reg[k] | (take ? (FACTOR_W'(1) << W) : '0);
                bl_lit_reg[k+1]  <= bl_lit_reg[k];
                bl_full_reg[k+1] <= bl_full_reg[k];
            end
        end
    end

    // Output register
    logic [FACTOR_W-1:0] factor;
    logic                m_is_lit_reg;
    logic [COS_W-1:0]    m_spot_factor_reg;

    always_comb begin
        if (bl_full_reg[BLEND_STEPS]) begin
            factor = UNIT_ONE;
        end else if (bl_lit_reg[BLEND_STEPS]) begin
            factor = bl_q_reg[BLEND_STEPS];
        end else begin
            factor = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            m_valid_reg <= bl_valid_reg[BLEND_STEPS];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            m_is_lit_reg      <= bl_lit_reg[BLEND_STEPS];
            m_spot_factor_reg <= factor[COS_W-1:0];
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_is_lit      = m_is_lit_reg;
    assign m_spot_factor = m_spot_factor_reg;

endmodule

[design/spca_checker.sv]
module spca_checker
    import spca_pkg::*;
(
    input logic                      aclk,
    input logic                      aresetn,
    input logic                      s_valid,
    input logic                      s_ready,
    input logic                      m_valid,
    input logic                      m_ready,
    input logic                      m_is_lit,
    input logic [COS_W-1:0]          m_spot_factor
);

    // A result waiting to be taken stays offered.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result transaction withdrawn before acceptance");

    // A stalled result keeps its payload.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> $stable(m_is_lit) && $stable(m_spot_factor))
        else $error("stalled result payload changed");

    // An unlit point never carries a nonzero factor.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_is_lit |-> m_spot_factor == '0)
        else $error("unlit result with nonzero spot factor");

    // The input buffer fills only from an accepted transaction during a stall.
    assert property (@(posedge aclk) disable iff (!aresetn)
        $fell(s_ready) |-> $past(s_valid) && $past(m_valid) && !$past(m_ready))
        else $error("input ready dropped without a stalled transaction");

    // Nothing comes out and the input is ready in the cycle after reset.
    assert property (@(posedge aclk)
        !aresetn |=> !m_valid && s_ready)
        else $error("pipeline not empty after reset");

endmodule

bind spotlight_cone_attenuation_unit spca_checker u_spca_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_valid       (s_valid),
    .s_ready       (s_ready),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_is_lit      (m_is_lit),
    .m_spot_factor (m_spot_factor)
);

[tb/tb_spotlight_cone_attenuation_unit.sv]
module tb_spotlight_cone_attenuation_unit;
    import spca_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int UFB      = 14;
    localparam int UNIT_ONE = 1 << UFB;
    localparam int PIPE_LAT = 56 + UFB;

    typedef struct {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] z;
    } point_t;

    typedef struct {
        logic             lit;
        logic [COS_W-1:0] factor;
    } shade_t;

    typedef enum int {
        PH_SENDER_IDLE,
        PH_RECEIVER_IDLE,
        PH_NO_IDLE
    } idle_phase_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic signed [COORD_W-1:0] s_point_x = '0;
    logic signed [COORD_W-1:0] s_point_y = '0;
    logic signed [COORD_W-1:0] s_point_z = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic m_is_lit;
    logic [COS_W-1:0] m_spot_factor;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // Shadow copy of the light registers.
    logic [31:0] lpos_x, lpos_y, lpos_z;
    logic [47:0] ldir;
    logic [COS_W-1:0] lcos_in, lcos_out;
    logic [RANGE_W-1:0] lrange;

    point_t pending_points[$];
    shade_t expected_shades[$];
    int errors = 0;
    idle_phase_t idle_phase = PH_SENDER_IDLE;
    int hold_cycles = 0;

    spotlight_cone_attenuation_unit uut (.*);

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    function automatic longint unsigned sqrt_floor(longint unsigned v);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic longint unsigned absval(longint v);
        return v < 0 ? longint'(-v) : v;
    endfunction

    function automatic shade_t shade_point(point_t p);
        shade_t r;
        longint d[3];
        longint dir[3];
        longint unsigned sumsq, len, q, rng;
        longint dot, c, gap;
        r.lit = 1'b0;
        r.factor = '0;
        d[0] = longint'(p.x) - longint'($signed(lpos_x));
        d[1] = longint'(p.y) - longint'($signed(lpos_y));
        d[2] = longint'(p.z) - longint'($signed(lpos_z));
        for (int i = 0; i < 3; i++) dir[i] = longint'($signed(ldir[16*i +: 16]));
        rng = lrange;
        sumsq = 0;
        for (int i = 0; i < 3; i++) begin
            if (absval(d[i]) > rng) return r;
            sumsq += absval(d[i]) * absval(d[i]);
        end
        if (sumsq > rng * rng) return r;
        if (sumsq == 0) begin
            r.lit = 1'b1;
            r.factor = COS_W'(UNIT_ONE);
            return r;
        end
        len = sqrt_floor(sumsq);
        dot = 0;
        for (int i = 0; i < 3; i++) dot += dir[i] * d[i];
        q = absval(dot) / len;
        c = dot < 0 ? -longint'(q) : longint'(q);
        if (c < longint'(lcos_out)) return r;
        r.lit = 1'b1;
        gap = longint'(lcos_in) - longint'(lcos_out);
        if (c > longint'(lcos_in) || gap < 1) r.factor = COS_W'(UNIT_ONE);
        else r.factor = COS_W'((c - longint'(lcos_out)) * UNIT_ONE / gap);
        return r;
    endfunction

    function automatic logic sender_idles();
        case (idle_phase)
            PH_SENDER_IDLE:   return $urandom_range(99) < 17;
            PH_RECEIVER_IDLE: return $urandom_range(99) < 81;
            default:          return 1'b0;
        endcase
    endfunction

    function automatic logic receiver_idles();
        case (idle_phase)
            PH_SENDER_IDLE:   return $urandom_range(99) < 81;
            PH_RECEIVER_IDLE: return $urandom_range(99) < 17;
            default:          return 1'b0;
        endcase
    endfunction

    // The handshake at the rising edge decides whether the driver moves on.
    logic s_took;
    always @(posedge aclk) s_took <= s_valid && s_ready;

    // Driver: a transaction completes at the rising edge, the next is presented at the fall.
    always @(negedge aclk) begin
        if (aresetn) begin
            if (!s_valid || s_took) begin
                if (pending_points.size() > 0 && !sender_idles()) begin
                    point_t p;
                    p = pending_points.pop_front();
                    expected_shades.push_back(shade_point(p));
                    s_point_x <= p.x;
                    s_point_y <= p.y;
                    s_point_z <= p.z;
                    s_valid <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    always @(negedge aclk) begin
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= aresetn && !receiver_idles();
        end
    end

    // Monitor.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (expected_shades.size() == 0) begin
                $display("%0t: unexpected result lit=%0b factor=%0d",
                         $realtime, m_is_lit, m_spot_factor);
                errors++;
            end else begin
                shade_t e;
                e = expected_shades.pop_front();
                if (m_is_lit !== e.lit) begin
                    $display("%0t: is_lit expected %0b actual %0b",
                             $realtime, e.lit, m_is_lit);
                    errors++;
                end
                if (m_spot_factor !== e.factor) begin
                    $display("%0t: spot_factor expected %0d actual %0d",
                             $realtime, e.factor, m_spot_factor);
                    errors++;
                end
            end
        end
    end

    task automatic write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] val);
        @(negedge aclk);
        cfg_index <= idx;
        cfg_data <= val;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_POS_X:       lpos_x = val[31:0];
            CFG_POS_Y:       lpos_y = val[31:0];
            CFG_POS_Z:       lpos_z = val[31:0];
            CFG_LIGHT_DIR:   ldir = val[47:0];
            CFG_COS_INNER:   lcos_in = val[COS_W-1:0];
            CFG_COS_OUTER:   lcos_out = val[COS_W-1:0];
            CFG_LIGHT_RANGE: lrange = val[RANGE_W-1:0];
            default: ;
        endcase
    endtask

    task automatic drain();
        wait (pending_points.size() == 0 && expected_shades.size() == 0);
        repeat (PIPE_LAT + 10) @(posedge aclk);
    endtask

    function automatic logic [31:0] rnd_near(logic [31:0] ctr, int unsigned span);
        return ctr + $signed($urandom_range(2 * span) - span);
    endfunction

    // Points are placed mostly close to the light so that the range and cone tests both matter.
    task automatic queue_random(int n);
        point_t p;
        int unsigned span;
        for (int i = 0; i < n; i++) begin
            case ($urandom_range(9))
                0: begin
                    p.x = $urandom; p.y = $urandom; p.z = $urandom;
                end
                1: begin
                    p.x = lpos_x; p.y = lpos_y; p.z = lpos_z;
                end
                default: begin
                    span = lrange > 32'h3fff_ffff ? 32'h7fff_ffff : 2 * lrange + 1;
                    if ($urandom_range(3) == 0) span = $urandom_range(64);
                    p.x = rnd_near(lpos_x, span);
                    p.y = rnd_near(lpos_y, span);
                    p.z = rnd_near(lpos_z, span);
                end
            endcase
            pending_points.push_back(p);
        end
    endtask

    task automatic queue_point(logic [31:0] x, logic [31:0] y, logic [31:0] z);
        point_t p;
        p.x = x; p.y = y; p.z = z;
        pending_points.push_back(p);
    endtask

    task automatic random_setting(logic extreme);
        logic [47:0] d;
        logic [14:0] a, b;
        write_reg(CFG_POS_X, extreme ? 48'($urandom) : 48'(32'($signed($urandom_range(2000000)) - 1000000)));
        write_reg(CFG_POS_Y, extreme ? 48'($urandom) : 48'(32'($signed($urandom_range(2000000)) - 1000000)));
        write_reg(CFG_POS_Z, extreme ? 48'($urandom) : 48'(32'($signed($urandom_range(2000000)) - 1000000)));
        d = {16'($urandom_range(32768) - 16384), 16'($urandom_range(32768) - 16384),
             16'($urandom_range(32768) - 16384)};
        if (extreme) d = {16'($urandom), 16'($urandom), 16'($urandom)};
        write_reg(CFG_LIGHT_DIR, d);
        a = 15'($urandom_range(16384));
        b = 15'($urandom_range(16384));
        if (extreme) begin
            a = 15'($urandom); b = 15'($urandom);
        end
        write_reg(CFG_COS_INNER, a > b ? a : b);
        write_reg(CFG_COS_OUTER, a > b ? b : a);
        write_reg(CFG_LIGHT_RANGE, extreme ? 48'(31'($urandom)) : 48'($urandom_range(4000000, 1)));
    endtask

    initial begin
        lpos_x = 0; lpos_y = 0; lpos_z = 0;
        ldir = dir_reset(UFB);
        lcos_in = cos_q30_to_unit(UFB, COS30_Q30);
        lcos_out = cos_q30_to_unit(UFB, COS45_Q30);
        lrange = RANGE_RESET;
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed: reset setting, zero offset, axis points, out of range, extremes.
        queue_point(0, 0, 0);
        queue_point(0, -32'sd65536, 0);
        queue_point(0, 32'sd65536, 0);
        queue_point(32'sd65536, -32'sd65536, 0);
        queue_point(32'sd40000, -32'sd65536, 0);
        queue_point(0, -32'sd655360, 0);
        queue_point(0, -32'sd655361, 0);
        queue_point(32'sd400000, -32'sd400000, 32'sd400000);
        queue_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        queue_point(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
        queue_point(32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff);
        drain();

        // Directed: extreme registers, equal and inverted cone, zero range, wide range.
        write_reg(CFG_POS_X, 48'h8000_0000);
        write_reg(CFG_POS_Y, 48'h7fff_ffff);
        write_reg(CFG_POS_Z, 48'h0);
        write_reg(CFG_LIGHT_DIR, 48'h8000_7fff_ffff);
        write_reg(CFG_COS_INNER, 48'h7fff);
        write_reg(CFG_COS_OUTER, 48'h0);
        write_reg(CFG_LIGHT_RANGE, 48'h7fff_ffff);
        queue_point(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff);
        queue_point(32'h8000_0000, 32'h7fff_ffff, 32'h0);
        queue_point(32'h8000_0001, 32'h7fff_fff0, 32'h10);
        queue_point(32'h0, 32'h0, 32'h8000_0000);
        drain();
        write_reg(CFG_COS_INNER, 48'd5000);
        write_reg(CFG_COS_OUTER, 48'd5000);
        write_reg(CFG_LIGHT_RANGE, 48'd0);
        queue_point(32'h8000_0000, 32'h7fff_ffff, 32'h0);
        queue_point(32'h8000_0001, 32'h7fff_ffff, 32'h0);
        drain();
        write_reg(CFG_COS_OUTER, 48'd9000);
        write_reg(CFG_LIGHT_RANGE, 48'd1000);
        write_reg(CFG_LIGHT_DIR, 48'h0000_0000_4000);
        queue_point(32'h8000_0100, 32'h7fff_ffff, 32'h0);
        queue_point(32'h8000_0100, 32'h7fff_ff00, 32'h0);
        drain();

        // Random phases with changing settings.
        for (int ph = 0; ph < 12; ph++) begin
            idle_phase = ph < 4 ? PH_SENDER_IDLE : (ph < 8 ? PH_RECEIVER_IDLE : PH_NO_IDLE);
            random_setting(ph % 4 == 3);
            queue_random(105);
            if (ph == 9) begin
                // Long receiver hold-off while the sender keeps offering.
                repeat (20) @(posedge aclk);
                hold_cycles = 300;
            end
            drain();
        end

        if (errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    initial begin
        #4_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule

[spotlight_cone_attenuation_unit.f]
design/spca_pkg.sv
design/spotlight_cone_attenuation_unit.sv
design/spca_checker.sv
tb/tb_spotlight_cone_attenuation_unit.sv
